/* hdl/irm_pkg.sv */
// Insulation resistance monitor: shared types, widths and constants.
// No dependencies; every other file of the block imports this package.
package irm_pkg;

  localparam int unsigned RAW_FIELD_W = 24;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SLOPE_W     = 40;
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned OFF_FRAC_W  = 8;
  localparam int unsigned OFF_SHIFT   = FRAC_W - OFF_FRAC_W;
  localparam int unsigned RES_W       = 24;
  localparam int unsigned NUM_W       = VAL_W + RES_W;
  localparam int unsigned DEN_W       = VAL_W + 1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = SLOPE_W;

  localparam logic [VAL_W-1:0] NOT_ESTIMATED = VAL_W'(999 << 16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH1_SLOPE  = 3'd0,
    CFG_CH1_OFFSET = 3'd1,
    CFG_CH2_SLOPE  = 3'd2,
    CFG_CH2_OFFSET = 3'd3,
    CFG_MIN_BUS    = 3'd4,
    CFG_DEADZONE   = 3'd5,
    CFG_INT_RES    = 3'd6,
    CFG_FAULT_THR  = 3'd7
  } irm_cfg_idx_e;

  typedef enum logic [1:0] {
    EST_NONE = 2'd0,
    EST_DIV  = 2'd1,
    EST_NEG  = 2'd2,
    EST_ERR  = 2'd3
  } irm_mode_e;

  typedef struct packed {
    logic [SLOPE_W-1:0]         ch1_slope;
    logic signed [OFFSET_W-1:0] ch1_offset;
    logic [SLOPE_W-1:0]         ch2_slope;
    logic signed [OFFSET_W-1:0] ch2_offset;
    logic [VAL_W-1:0]           min_bus;
    logic [VAL_W-1:0]           deadzone;
    logic [RES_W-1:0]           internal_resistance;
    logic [VAL_W-1:0]           fault_threshold;
  } irm_cfg_t;

  localparam irm_cfg_t CFG_RESET = '{
    ch1_slope:           40'd225872,
    ch1_offset:          32'sd225,
    ch2_slope:           40'd233100,
    ch2_offset:          32'sd233,
    min_bus:             32'd50,
    deadzone:            32'd20,
    internal_resistance: 24'd131072,
    fault_threshold:     32'd29491
  };

  typedef struct packed {
    logic [RAW_FIELD_W-1:0] raw_ch1;
    logic [RAW_FIELD_W-1:0] raw_ch2;
  } irm_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] ch1_value;
    logic [VAL_W-1:0] ch2_value;
    logic [VAL_W-1:0] bus_net;
    logic [VAL_W-1:0] insulation;
    logic             fault;
    logic             reading_error;
  } irm_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] v1;
    logic [VAL_W-1:0] v2;
    logic             err;
  } irm_cal_t;

  typedef struct packed {
    logic [VAL_W-1:0] v1;
    logic [VAL_W-1:0] v2;
    irm_mode_e        mode;
  } irm_side_t;

  // quo holds the low dividend bits on entry and the quotient on exit
  typedef struct packed {
    logic [VAL_W-1:0] quo;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             ovf;
    irm_side_t        side;
  } irm_div_t;

endpackage

/* hdl/irm_if.sv */
// Stream interfaces for the input pair and the result word.
// Depends on irm_pkg for the payload structs.
interface irm_in_if;
  import irm_pkg::*;
  logic    valid;
  logic    ready;
  irm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface irm_out_if;
  import irm_pkg::*;
  logic     valid;
  logic     ready;
  irm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/irm_calib.sv */
// Three-stage calibration of both channels: partial products, exact sum,
// round half up with saturation and sign check. Depends on irm_pkg.
module irm_calib #(
  parameter int unsigned RAW_W = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irm_pkg::irm_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RAW_W-1:0]    raw1_i,
  input  logic [RAW_W-1:0]    raw2_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output irm_pkg::irm_cal_t   out_o
);
  import irm_pkg::*;

  localparam int unsigned NCH   = 2;
  localparam int unsigned LO_W  = RAW_W + FRAC_W;
  localparam int unsigned HI_W  = RAW_W + SLOPE_W - FRAC_W;
  localparam int unsigned SUM_W =
    ((RAW_W + SLOPE_W > 2 * VAL_W) ? RAW_W + SLOPE_W : 2 * VAL_W) + 2;
  localparam int unsigned INT_W = SUM_W - FRAC_W;

  function automatic logic [SUM_W-1:0] cal_sum(input logic [HI_W-1:0] phi,
                                               input logic [LO_W-1:0] plo,
                                               input logic [OFFSET_W-1:0] off);
    logic [SUM_W-1:0] hi_ext;
    logic [SUM_W-1:0] lo_ext;
    logic [SUM_W-1:0] off_ext;
    hi_ext  = {{(SUM_W-HI_W-FRAC_W){1'b0}}, phi, {FRAC_W{1'b0}}};
    lo_ext  = {{(SUM_W-LO_W){1'b0}}, plo};
    off_ext = {{(SUM_W-OFFSET_W-OFF_SHIFT){off[OFFSET_W-1]}}, off, {OFF_SHIFT{1'b0}}};
    return hi_ext + lo_ext + off_ext;
  endfunction

  logic [2:0]          valid_q;
  logic                en;
  logic [RAW_W-1:0]    raw[NCH];
  logic [SLOPE_W-1:0]  slope[NCH];
  logic [OFFSET_W-1:0] offs[NCH];
  logic [LO_W-1:0]     plo_q[NCH];
  logic [HI_W-1:0]     phi_q[NCH];
  logic [SUM_W-1:0]    sum_q[NCH];
  logic [INT_W:0]      rnd[NCH];
  logic [VAL_W-1:0]    val_d[NCH];
  logic [NCH-1:0]      neg_d;
  irm_cal_t            out_q;

  assign en          = !valid_q[2] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[2];
  assign out_o       = out_q;

  always_comb begin
    raw[0]   = raw1_i;
    raw[1]   = raw2_i;
    slope[0] = cfg_i.ch1_slope;
    slope[1] = cfg_i.ch2_slope;
    offs[0]  = cfg_i.ch1_offset;
    offs[1]  = cfg_i.ch2_offset;
    for (int c = 0; c < NCH; c++) begin
      rnd[c]   = {1'b0, sum_q[c][SUM_W-1:FRAC_W]} +
                 {{INT_W{1'b0}}, sum_q[c][FRAC_W-1]};
      neg_d[c] = sum_q[c][SUM_W-1];
      val_d[c] = (|rnd[c][INT_W:VAL_W]) ? '1 : rnd[c][VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        plo_q[c] <= LO_W'(raw[c]) * LO_W'(slope[c][FRAC_W-1:0]);
        phi_q[c] <= HI_W'(raw[c]) * HI_W'(slope[c][SLOPE_W-1:FRAC_W]);
        sum_q[c] <= cal_sum(phi_q[c], plo_q[c], offs[c]);
      end
      out_q.v1  <= val_d[0];
      out_q.v2  <= val_d[1];
      out_q.err <= |neg_d;
    end
  end

endmodule

/* hdl/irm_est.sv */
// Bridge model selection, numerator product and overflow check ahead of
// the divider; three register stages. Depends on irm_pkg.
module irm_est (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irm_pkg::irm_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  irm_pkg::irm_cal_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output irm_pkg::irm_div_t out_o
);
  import irm_pkg::*;

  logic [2:0]       valid_q;
  logic             en;
  logic [VAL_W:0]   two_v2;
  logic [VAL_W:0]   two_dz;
  logic [VAL_W+1:0] lo_lhs;
  logic [VAL_W+1:0] up_rhs;
  logic             is_lo;
  logic             is_up;
  irm_mode_e        mode_d;
  logic [DEN_W-1:0] den_d;
  logic [VAL_W-1:0] opnd_d;
  irm_side_t        side0_q;
  logic [DEN_W-1:0] den0_q;
  logic [VAL_W-1:0] opnd0_q;
  irm_side_t        side1_q;
  logic [DEN_W-1:0] den1_q;
  logic [NUM_W-1:0] num1_q;
  logic [RES_W-1:0] num_hi;
  logic             ovf_d;
  irm_div_t         out_q;

  assign en          = !valid_q[2] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[2];
  assign out_o       = out_q;

  always_comb begin
    two_v2 = {in_i.v2, 1'b0};
    two_dz = {cfg_i.deadzone, 1'b0};
    lo_lhs = {1'b0, two_v2} + {1'b0, two_dz};
    up_rhs = {2'b00, in_i.v1} + {1'b0, two_dz};
    is_lo  = lo_lhs < {2'b00, in_i.v1};
    is_up  = {1'b0, two_v2} > up_rhs;
    mode_d = EST_NONE;
    den_d  = '0;
    opnd_d = '0;
    if (in_i.err) begin
      mode_d = EST_ERR;
    end else if (in_i.v1 > cfg_i.min_bus) begin
      if (is_lo) begin
        mode_d = EST_DIV;
        den_d  = {1'b0, in_i.v1} - two_v2;
        opnd_d = in_i.v2;
      end else if (is_up) begin
        if (in_i.v2 > in_i.v1) begin
          mode_d = EST_NEG;
        end else begin
          mode_d = EST_DIV;
          den_d  = two_v2 - {1'b0, in_i.v1};
          opnd_d = in_i.v1 - in_i.v2;
        end
      end
    end
  end

  // quotient fits 32 bits only when the upper numerator bits stay below den
  always_comb begin
    num_hi = num1_q[NUM_W-1:VAL_W];
    ovf_d  = DEN_W'(num_hi) >= den1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q.v1   <= in_i.v1;
      side0_q.v2   <= in_i.v2;
      side0_q.mode <= mode_d;
      den0_q       <= den_d;
      opnd0_q      <= opnd_d;
      side1_q      <= side0_q;
      den1_q       <= den0_q;
      num1_q       <= NUM_W'(opnd0_q) * NUM_W'(cfg_i.internal_resistance);
      out_q.quo    <= num1_q[VAL_W-1:0];
      out_q.rem    <= ovf_d ? '0 : DEN_W'(num_hi);
      out_q.den    <= den1_q;
      out_q.ovf    <= ovf_d;
      out_q.side   <= side1_q;
    end
  end

`ifndef SYNTHESIS
  a_div_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && side0_q.mode == EST_DIV |-> den0_q != '0)
    else $error("bridge divisor is zero");
`endif

endmodule

/* hdl/irm_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on irm_pkg for the stage word layout.
module irm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  irm_pkg::irm_div_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output irm_pkg::irm_div_t out_o
);
  import irm_pkg::*;

  localparam int unsigned NS = VAL_W;

  logic [NS-1:0]    valid_q;
  logic             en;
  irm_div_t         src[NS];
  irm_div_t         st_d[NS];
  irm_div_t         st_q[NS];
  logic [DEN_W:0]   trial[NS];

  assign en          = !valid_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NS-1];
  assign out_o       = st_q[NS-1];

  always_comb begin
    src[0] = in_i;
    for (int k = 1; k < NS; k++) begin
      src[k] = st_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      trial[k] = {src[k].rem, src[k].quo[VAL_W-1]};
      st_d[k]  = src[k];
      if (trial[k] >= {1'b0, src[k].den}) begin
        st_d[k].rem = DEN_W'(trial[k] - {1'b0, src[k].den});
        st_d[k].quo = {src[k].quo[VAL_W-2:0], 1'b1};
      end else begin
        st_d[k].rem = trial[k][DEN_W-1:0];
        st_d[k].quo = {src[k].quo[VAL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.side.mode == EST_DIV && !out_o.ovf |-> out_o.rem < out_o.den)
    else $error("divider remainder not below divisor");
`endif

endmodule

/* hdl/insulation_resistance_monitor.sv */
// Insulation resistance monitor top: config registers, calibration, bridge
// estimate, 32-stage divider and output register. A word passes through
// the calibration, estimate, divider and output registers in order; one
// word per cycle sustained unless out_o.ready stalls; one bit per divider stage.
// Reset clears all valid bits and loads the config defaults; no clear pass.
// Depends on irm_pkg, irm_if, irm_calib, irm_est and irm_div.
module insulation_resistance_monitor #(
  parameter int unsigned RAW_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [irm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  irm_in_if.sink                           in_i,
  irm_out_if.source                        out_o
);
  import irm_pkg::*;

  localparam int unsigned RAW_W = (RAW_BITS < RAW_FIELD_W) ? RAW_BITS : RAW_FIELD_W;

  irm_cfg_t cfg_q;
  logic     cal_valid;
  logic     cal_ready;
  irm_cal_t cal_word;
  logic     est_valid;
  logic     est_ready;
  irm_div_t est_word;
  logic     div_valid;
  logic     div_ready;
  irm_div_t div_word;
  logic     out_valid_q;
  irm_out_t out_q;
  irm_out_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (irm_cfg_idx_e'(cfg_index_i))
        CFG_CH1_SLOPE:  cfg_q.ch1_slope           <= cfg_wdata_i[SLOPE_W-1:0];
        CFG_CH1_OFFSET: cfg_q.ch1_offset          <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_CH2_SLOPE:  cfg_q.ch2_slope           <= cfg_wdata_i[SLOPE_W-1:0];
        CFG_CH2_OFFSET: cfg_q.ch2_offset          <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_MIN_BUS:    cfg_q.min_bus             <= cfg_wdata_i[VAL_W-1:0];
        CFG_DEADZONE:   cfg_q.deadzone            <= cfg_wdata_i[VAL_W-1:0];
        CFG_INT_RES:    cfg_q.internal_resistance <= cfg_wdata_i[RES_W-1:0];
        CFG_FAULT_THR:  cfg_q.fault_threshold     <= cfg_wdata_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  irm_calib #(
    .RAW_W (RAW_W)
  ) u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .raw1_i      (in_i.data.raw_ch1[RAW_W-1:0]),
    .raw2_i      (in_i.data.raw_ch2[RAW_W-1:0]),
    .out_valid_o (cal_valid),
    .out_ready_i (cal_ready),
    .out_o       (cal_word)
  );

  irm_est u_est (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (cal_valid),
    .in_ready_o  (cal_ready),
    .in_i        (cal_word),
    .out_valid_o (est_valid),
    .out_ready_i (est_ready),
    .out_o       (est_word)
  );

  irm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (est_valid),
    .in_ready_o  (est_ready),
    .in_i        (est_word),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_word)
  );

  assign div_ready = !out_valid_q || out_o.ready;

  always_comb begin
    res_d = '0;
    unique case (div_word.side.mode)
      EST_ERR: begin
        res_d.reading_error = 1'b1;
      end
      EST_NONE: begin
        res_d.insulation = NOT_ESTIMATED;
      end
      EST_NEG: begin
        res_d.fault = 1'b1;
      end
      EST_DIV: begin
        res_d.insulation = div_word.ovf ? '1 : div_word.quo;
        res_d.fault      = !div_word.ovf && (div_word.quo < cfg_q.fault_threshold);
      end
      default: ;
    endcase
    if (div_word.side.mode != EST_ERR) begin
      res_d.ch1_value = div_word.side.v1;
      res_d.ch2_value = div_word.side.v2;
      res_d.bus_net   = (div_word.side.v1 > div_word.side.v2) ?
                        div_word.side.v1 - div_word.side.v2 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.reading_error |->
      out_q.ch1_value == '0 && out_q.ch2_value == '0 && out_q.bus_net == '0 &&
      out_q.insulation == '0 && !out_q.fault)
    else $error("reading error with nonzero result fields");

  a_fault_below_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.reading_error && out_q.fault |->
      out_q.insulation == '0 || out_q.insulation < cfg_q.fault_threshold)
    else $error("fault raised with estimate at or above threshold");

  a_net_not_above_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.bus_net <= out_q.ch1_value)
    else $error("bus_net exceeds channel 1 value");
`endif

endmodule
